[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define AST_HOLDS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define AST_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[rtl/mrfp_pkg.sv]
// ----------------------------------------------------------------------------
// Meter readout frame parser package
// Character codes, parser phase codes and result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfp_pkg;

   localparam int unsigned IdMax = 64;

   localparam logic [7:0] ChStx   = 8'h02;
   localparam logic [7:0] ChEtx   = 8'h03;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChStart = 8'h2F;
   localparam logic [7:0] ChEnd   = 8'h21;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab   = 8'h09;

   localparam logic [3:0] PhIdle   = 4'd0;
   localparam logic [3:0] PhId     = 4'd1;
   localparam logic [3:0] PhIdLf   = 4'd2;
   localparam logic [3:0] PhStx    = 4'd3;
   localparam logic [3:0] PhData   = 4'd4;
   localparam logic [3:0] PhDataLf = 4'd5;
   localparam logic [3:0] PhEndCr  = 4'd6;
   localparam logic [3:0] PhEndLf  = 4'd7;
   localparam logic [3:0] PhEtx    = 4'd8;
   localparam logic [3:0] PhBbc    = 4'd9;

   typedef logic [1:0] kind_type;
   localparam kind_type KindIdChar   = 2'd0;
   localparam kind_type KindDataChar = 2'd1;
   localparam kind_type KindLineEnd  = 2'd2;
   localparam kind_type KindFrameEnd = 2'd3;

   typedef logic [6:0] count_type;

   // Space, and tab through carriage return, count as trailing whitespace.
   function automatic logic is_blank(input logic [7:0] c);
      return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
   endfunction

endpackage

`default_nettype wire

[rtl/meter_readout_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// Meter readout frame parser unit
// Input register, then result register; one byte per cycle unless stalled.
// The input register and the result register stall together on rsp_ready.
// Synchronous reset returns the parser to idle with empty counts and check.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module meter_readout_frame_parser_unit
   import mrfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_rx_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [1:0] rsp_kind,
   output      logic [7:0] rsp_char_value,
   output      logic [6:0] rsp_id_length,
   output      logic       rsp_check_ok,
   output      logic       rsp_missing_stx
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   logic [3:0] phase_ff, phase_in;
   logic [7:0] check_ff, check_in;
   count_type  id_count_ff, id_count_in;
   count_type  id_trim_ff, id_trim_in;

   logic       out_valid_ff, out_valid_in;
   kind_type   out_kind_ff, out_kind_in;
   logic [7:0] out_char_ff, out_char_in;
   count_type  out_len_ff, out_len_in;
   logic       out_ok_ff, out_ok_in;
   logic       out_nostx_ff, out_nostx_in;

   logic       out_free;
   logic       work_fire;
   logic       emit;
   logic [7:0] c;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign work_fire = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign c         = in_byte_ff;

   // Next parser state and the result caused by the registered byte.
   always_comb begin
      phase_in    = phase_ff;
      check_in    = check_ff;
      id_count_in = id_count_ff;
      id_trim_in  = id_trim_ff;
      emit        = 1'b0;
      out_kind_in = KindIdChar;
      out_char_in = 8'h00;
      out_len_in  = '0;
      out_ok_in   = 1'b0;
      out_nostx_in = 1'b0;
      unique case (phase_ff)
         PhId: begin
            if (c == ChCr) begin
               phase_in = PhIdLf;
            end else if (id_count_ff < count_type'(IdMax)) begin
               id_count_in = id_count_ff + 7'd1;
               if (!is_blank(c)) begin
                  id_trim_in = id_count_ff + 7'd1;
               end
               emit        = 1'b1;
               out_kind_in = KindIdChar;
               out_char_in = c;
            end
         end
         PhIdLf: begin
            phase_in = (c == ChLf) ? PhStx : PhIdle;
         end
         PhStx: begin
            if (c == ChStx) begin
               phase_in = PhData;
            end else begin
               phase_in     = PhIdle;
               emit         = 1'b1;
               out_kind_in  = KindFrameEnd;
               out_len_in   = id_trim_ff;
               out_nostx_in = 1'b1;
            end
         end
         PhData: begin
            check_in = check_ff ^ c;
            if (c == ChEnd) begin
               phase_in = PhEndCr;
            end else if (c == ChCr) begin
               phase_in    = PhDataLf;
               emit        = 1'b1;
               out_kind_in = KindLineEnd;
            end else begin
               emit        = 1'b1;
               out_kind_in = KindDataChar;
               out_char_in = c;
            end
         end
         PhDataLf: begin
            check_in = check_ff ^ c;
            phase_in = (c == ChLf) ? PhData : PhIdle;
         end
         PhEndCr: begin
            check_in = check_ff ^ c;
            phase_in = (c == ChCr) ? PhEndLf : PhIdle;
         end
         PhEndLf: begin
            check_in = check_ff ^ c;
            phase_in = (c == ChLf) ? PhEtx : PhIdle;
         end
         PhEtx: begin
            if (c == ChEtx) begin
               check_in = check_ff ^ c;
               phase_in = PhBbc;
            end else begin
               phase_in = PhIdle;
            end
         end
         PhBbc: begin
            phase_in    = PhIdle;
            emit        = 1'b1;
            out_kind_in = KindFrameEnd;
            out_len_in  = id_trim_ff;
            out_ok_in   = (check_ff == c);
         end
         default: begin
            // Idle and unused codes wait for the frame start character.
            phase_in = PhIdle;
            if (c == ChStart) begin
               check_in    = 8'h00;
               id_count_in = '0;
               id_trim_in  = '0;
               phase_in    = PhId;
            end
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (work_fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (work_fire) begin
         out_valid_in = emit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PhIdle;
         check_ff     <= 8'h00;
         id_count_ff  <= '0;
         id_trim_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (work_fire) begin
            phase_ff    <= phase_in;
            check_ff    <= check_in;
            id_count_ff <= id_count_in;
            id_trim_ff  <= id_trim_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (work_fire && emit) begin
         out_kind_ff  <= out_kind_in;
         out_char_ff  <= out_char_in;
         out_len_ff   <= out_len_in;
         out_ok_ff    <= out_ok_in;
         out_nostx_ff <= out_nostx_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_char_value  = out_char_ff;
   assign rsp_id_length   = out_len_ff;
   assign rsp_check_ok    = out_ok_ff;
   assign rsp_missing_stx = out_nostx_ff;

   `AST_HOLDS(a_trim_le_count, id_trim_ff <= id_count_ff, "trimmed length exceeds count")
   `AST_HOLDS(a_count_le_max, id_count_ff <= count_type'(IdMax), "id count beyond limit")
   `AST_NEVER(a_end_both_flags, out_valid_ff && out_ok_ff && out_nostx_ff, "check_ok with missing STX")
   `AST_HOLDS(a_line_end_no_char, (out_valid_ff && out_kind_ff == KindLineEnd) |-> (out_char_ff == 8'h00), "line end carries a character")
   `AST_HOLDS(a_stall_holds_byte, (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_byte_ff)), "stalled input byte lost")

endmodule

`default_nettype wire
